@@ rtl/core/rpsd_pkg.sv @@
// Package for the register pair scaled decoder: status, type and word order codes,
// plus the count-leading-zeros and float round/pack helpers used by the datapath.
// No dependencies.
`default_nettype none
package rpsd_pkg;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ARG    = 2'd1;
	localparam logic [1:0] ST_UNSUP  = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	localparam logic [2:0] T_U16 = 3'd0;
	localparam logic [2:0] T_I16 = 3'd1;
	localparam logic [2:0] T_U32 = 3'd2;
	localparam logic [2:0] T_I32 = 3'd3;
	localparam logic [2:0] T_F32 = 3'd4;

	localparam logic [2:0] ORD_ABCD = 3'd0;
	localparam logic [2:0] ORD_CDAB = 3'd1;
	localparam logic [2:0] ORD_BADC = 3'd2;
	localparam logic [2:0] ORD_DCBA = 3'd3;

	localparam logic [7:0] EXP_MAX = 8'hFF;

	function automatic logic [31:0] assemble32(input logic [15:0] w0, input logic [15:0] w1,
		input logic [2:0] order);
		logic [31:0] r;
		case (order)
			ORD_CDAB: r = {w1, w0};
			ORD_BADC: r = {w0[7:0], w0[15:8], w1[7:0], w1[15:8]};
			ORD_DCBA: r = {w1[7:0], w1[15:8], w0[7:0], w0[15:8]};
			default:  r = {w0, w1};
		endcase
		return r;
	endfunction

	function automatic logic [5:0] lzc32(input logic [31:0] x);
		logic [5:0] n;
		logic found;
		n = 6'd32;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && x[i]) begin
				n = 6'(31 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// m has its leading one at bit 63; value is 1.m * 2^(eb - 127)
	function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] eb,
		input logic zero, input logic [63:0] m);
		logic signed [12:0] d;
		logic [6:0] sh;
		logic [63:0] x;
		logic lost;
		logic [23:0] mant;
		logic g;
		logic st;
		logic up;
		logic [24:0] r;
		logic [11:0] base;
		logic [12:0] ef;
		logic [31:0] res;
		d = 13'sd1 - {eb[11], eb};
		if (eb >= 12'sd1) sh = 7'd0;
		else if (d > 13'sd63) sh = 7'd63;
		else sh = d[6:0];
		x = m >> sh;
		lost = ((x << sh) != m);
		mant = x[63:40];
		g = x[39];
		st = (|x[38:0]) | lost;
		up = g & (st | mant[0]);
		r = {1'b0, mant} + {24'd0, up};
		base = (eb >= 12'sd1) ? 12'(eb - 12'sd1) : 12'd0;
		ef = {1'b0, base} + {11'd0, r[24:23]};
		if (zero) res = {sgn, 31'd0};
		else if (ef >= 13'd255) res = {sgn, EXP_MAX, 23'd0};
		else res = {sgn, ef[7:0], r[22:0]};
		return res;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/register_pair_scaled_decoder_unit.sv @@
// Register pair scaled decoder: decodes a value from one or two 16-bit words, converts
// it to IEEE single, multiplies by scale and adds offset with separate RNE roundings.
// Depends on rpsd_pkg.
//
// Usage:
//   Input channel: in_valid/in_stall with reg_first, reg_second, available_count,
//   data_type, word_order, scale_bits, offset_bits. A request is taken at a clock
//   edge where in_valid is high and in_stall is low.
//   Output channel: out_valid/out_stall with status and value_bits, one result per
//   request, in request order. value_bits is zero whenever status is not ok.
//   Pipeline: a request passes through an eight-stage pipeline whose first stage
//   loads at the accepting edge (decode, normalize, integer round, multiply,
//   product round, align, add, normalize and round); out_valid shows the last stage.
//   Throughput: one request per cycle while in_stall is low.
//   Stall: a stage advances when it is empty or the next stage advances, so bubbles
//   collapse; in_stall rises only once every stage holds a request. Results are held
//   stable while out_stall is high.
//   Reset: arst_n clears all stage valid bits; the pipeline comes up empty.
`default_nettype none
module register_pair_scaled_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] reg_first,
	input  wire logic [15:0] reg_second,
	input  wire logic [1:0]  available_count,
	input  wire logic [2:0]  data_type,
	input  wire logic [2:0]  word_order,
	input  wire logic [31:0] scale_bits,
	input  wire logic [31:0] offset_bits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      value_bits
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;

	assign adv8 = !v_s8 || !out_stall;
	assign adv7 = !v_s7 || adv8;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign out_valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
			if (adv8) v_s8 <= v_s7;
		end
	end

	// decode
	logic [31:0] raw_a;
	logic [1:0]  st_a;
	logic        sg_a;
	logic [31:0] m_a;
	logic signed [11:0] eb_a;
	logic [31:0] sx16_a;
	logic        cnt_bad_a;

	always_comb begin
		raw_a = rpsd_pkg::assemble32(reg_first, reg_second, word_order);
		sx16_a = {{16{reg_first[15]}}, reg_first};
		cnt_bad_a = (data_type > rpsd_pkg::T_I16) ? (available_count < 2'd2)
			: (available_count < 2'd1);
		if (cnt_bad_a || scale_bits[30:23] == rpsd_pkg::EXP_MAX
			|| offset_bits[30:23] == rpsd_pkg::EXP_MAX) st_a = rpsd_pkg::ST_ARG;
		else if (data_type > rpsd_pkg::T_F32) st_a = rpsd_pkg::ST_UNSUP;
		else if (data_type == rpsd_pkg::T_F32 && raw_a[30:23] == rpsd_pkg::EXP_MAX)
			st_a = rpsd_pkg::ST_RESP;
		else st_a = rpsd_pkg::ST_OK;
		sg_a = 1'b0;
		m_a = raw_a;
		eb_a = 12'sd31;
		case (data_type)
			rpsd_pkg::T_U16: m_a = {16'd0, reg_first};
			rpsd_pkg::T_I16: begin
				sg_a = reg_first[15];
				m_a = sg_a ? 32'(-sx16_a) : sx16_a;
			end
			rpsd_pkg::T_I32: begin
				sg_a = raw_a[31];
				m_a = sg_a ? 32'(-raw_a) : raw_a;
			end
			rpsd_pkg::T_F32: begin
				sg_a = raw_a[31];
				m_a = {(raw_a[30:23] != 8'd0), raw_a[22:0], 8'd0};
				eb_a = (raw_a[30:23] == 8'd0) ? -12'sd126
					: $signed({4'd0, raw_a[30:23]}) - 12'sd127;
			end
			default: m_a = raw_a;
		endcase
	end

	logic [1:0]  st_s1;
	logic        sg_s1;
	logic [31:0] m_s1;
	logic signed [11:0] e_s1;
	logic [31:0] sc_s1, of_s1;

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			st_s1 <= st_a; sg_s1 <= sg_a; m_s1 <= m_a; e_s1 <= eb_a;
			sc_s1 <= scale_bits; of_s1 <= offset_bits;
		end
	end

	// normalize value and scale
	logic [31:0] sm_b;
	logic [5:0]  vlz_b, slz_b;
	logic signed [11:0] se_b;
	assign sm_b = {(sc_s1[30:23] != 8'd0), sc_s1[22:0], 8'd0};
	assign vlz_b = rpsd_pkg::lzc32(m_s1);
	assign slz_b = rpsd_pkg::lzc32(sm_b);
	assign se_b = (sc_s1[30:23] == 8'd0) ? -12'sd126 : $signed({4'd0, sc_s1[30:23]}) - 12'sd127;

	logic [1:0]  st_s2;
	logic        vs_s2, vz_s2, ss_s2, sz_s2;
	logic [31:0] vm_s2, sm_s2, of_s2;
	logic signed [11:0] ve_s2, se_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			st_s2 <= st_s1; vs_s2 <= sg_s1; vz_s2 <= (m_s1 == 32'd0);
			vm_s2 <= m_s1 << vlz_b; ve_s2 <= e_s1 - $signed({6'd0, vlz_b});
			ss_s2 <= sc_s1[31]; sz_s2 <= (sm_b == 32'd0);
			sm_s2 <= sm_b << slz_b; se_s2 <= se_b - $signed({6'd0, slz_b});
			of_s2 <= of_s1;
		end
	end

	// round integer value to 24 bits
	logic        up_c;
	logic [24:0] r_c;
	assign up_c = vm_s2[7] & ((|vm_s2[6:0]) | vm_s2[8]);
	assign r_c = {1'b0, vm_s2[31:8]} + {24'd0, up_c};

	logic [1:0]  st_s3;
	logic        vs_s3, vz_s3, ss_s3, sz_s3;
	logic [23:0] vm_s3, sm_s3;
	logic signed [11:0] ve_s3, se_s3;
	logic [31:0] of_s3;

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			st_s3 <= st_s2; vs_s3 <= vs_s2; vz_s3 <= vz_s2; ss_s3 <= ss_s2; sz_s3 <= sz_s2;
			vm_s3 <= r_c[24] ? 24'h800000 : r_c[23:0];
			ve_s3 <= ve_s2 + $signed({11'd0, r_c[24]});
			sm_s3 <= sm_s2[31:8]; se_s3 <= se_s2; of_s3 <= of_s2;
		end
	end

	// multiply
	logic [1:0]  st_s4;
	logic        ps_s4, pz_s4;
	logic [47:0] pm_s4;
	logic signed [11:0] pe_s4;
	logic [31:0] of_s4;

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			st_s4 <= st_s3; ps_s4 <= vs_s3 ^ ss_s3; pz_s4 <= vz_s3 | sz_s3;
			pm_s4 <= vm_s3 * sm_s3; pe_s4 <= ve_s3 + se_s3; of_s4 <= of_s3;
		end
	end

	// round product; an overflowed product sets status resp whatever the offset
	logic signed [11:0] peb_e;
	logic [63:0] pm64_e;
	logic [31:0] pb_e;
	assign peb_e = pe_s4 + 12'sd127 + $signed({11'd0, pm_s4[47]});
	assign pm64_e = pm_s4[47] ? {pm_s4, 16'd0} : {pm_s4[46:0], 17'd0};
	assign pb_e = rpsd_pkg::round_pack(ps_s4, peb_e, pz_s4, pm64_e);

	logic [1:0]  st_s5;
	logic [31:0] pb_s5, of_s5;

	always_ff @(posedge clk) begin
		if (adv5 && v_s4) begin
			st_s5 <= (st_s4 == rpsd_pkg::ST_OK && pb_e[30:23] == rpsd_pkg::EXP_MAX)
				? rpsd_pkg::ST_RESP : st_s4;
			pb_s5 <= pb_e;
			of_s5 <= of_s4;
		end
	end

	// align
	logic        pbig_f;
	logic [31:0] big_f, sml_f;
	logic [7:0]  ebig_f, esml_f, d_f;
	logic [4:0]  dsh_f;
	logic [26:0] s27_f, x_f;
	logic        lost_f;

	always_comb begin
		pbig_f = pb_s5[30:0] >= of_s5[30:0];
		big_f = pbig_f ? pb_s5 : of_s5;
		sml_f = pbig_f ? of_s5 : pb_s5;
		ebig_f = (big_f[30:23] == 8'd0) ? 8'd1 : big_f[30:23];
		esml_f = (sml_f[30:23] == 8'd0) ? 8'd1 : sml_f[30:23];
		d_f = ebig_f - esml_f;
		dsh_f = (d_f > 8'd27) ? 5'd27 : d_f[4:0];
		s27_f = {(sml_f[30:23] != 8'd0), sml_f[22:0], 3'd0};
		x_f = s27_f >> dsh_f;
		lost_f = ((x_f << dsh_f) != s27_f);
	end

	logic [1:0]  st_s6;
	logic [26:0] bg_s6, sm27_s6;
	logic [7:0]  eb_s6;
	logic        sg_s6, sub_s6, bn_s6;

	always_ff @(posedge clk) begin
		if (adv6 && v_s5) begin
			st_s6 <= st_s5;
			bg_s6 <= {(big_f[30:23] != 8'd0), big_f[22:0], 3'd0};
			sm27_s6 <= x_f | {26'd0, lost_f};
			eb_s6 <= ebig_f; sg_s6 <= big_f[31];
			sub_s6 <= pb_s5[31] ^ of_s5[31]; bn_s6 <= pb_s5[31] & of_s5[31];
		end
	end

	// add
	logic [27:0] sum_g;
	assign sum_g = sub_s6 ? ({1'b0, bg_s6} - {1'b0, sm27_s6}) : ({1'b0, bg_s6} + {1'b0, sm27_s6});

	logic [1:0]  st_s7;
	logic [27:0] sum_s7;
	logic [5:0]  lz_s7;
	logic [7:0]  eb_s7;
	logic        sg_s7, bn_s7;

	always_ff @(posedge clk) begin
		if (adv7 && v_s6) begin
			st_s7 <= st_s6; sum_s7 <= sum_g; lz_s7 <= rpsd_pkg::lzc32({sum_g, 4'd0});
			eb_s7 <= eb_s6; sg_s7 <= sg_s6; bn_s7 <= bn_s6;
		end
	end

	// normalize and round sum
	logic        z_h;
	logic [31:0] nrm_h, bits_h;
	logic signed [11:0] seb_h;
	assign z_h = (sum_s7 == 28'd0);
	assign nrm_h = {sum_s7, 4'd0} << lz_s7;
	assign seb_h = $signed({4'd0, eb_s7}) + 12'sd1 - $signed({6'd0, lz_s7});
	assign bits_h = rpsd_pkg::round_pack(z_h ? bn_s7 : sg_s7, seb_h, z_h, {nrm_h, 32'd0});

	always_ff @(posedge clk) begin
		if (adv8 && v_s7) begin
			if (st_s7 != rpsd_pkg::ST_OK) begin
				status <= st_s7; value_bits <= 32'd0;
			end else if (bits_h[30:23] == rpsd_pkg::EXP_MAX) begin
				status <= rpsd_pkg::ST_RESP; value_bits <= 32'd0;
			end else begin
				status <= rpsd_pkg::ST_OK; value_bits <= bits_h;
			end
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rpsd_pkg::ST_OK |-> value_bits == 32'd0)
		else $error("nonzero value with error status");
	a_ok_finite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rpsd_pkg::ST_OK |-> value_bits[30:23] != rpsd_pkg::EXP_MAX)
		else $error("non-finite result with ok status");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s8 && out_stall)
		else $error("input stalled with room in pipeline");
	a_prod_norm: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !pz_s4 && st_s4 == rpsd_pkg::ST_OK |-> pm_s4[47] || pm_s4[46])
		else $error("product mantissa not normalized");

endmodule
`default_nettype wire
